// ----- hw/rtl/sha256_stream_hasher_top_defines.svh -----
// Assertion macros shared by the SHA-256 stream hasher RTL.
// Users must have clk and rst in scope; no other dependencies.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sha256sh_pkg.sv -----
// Package for the SHA-256 stream hasher: round constants, initial hash
// values, the sigma functions and the control types. No dependencies.
package sha256sh_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPadPos  = 56;
  localparam logic [7:0]  PadMarker  = 8'h80;
  localparam logic [60:0] LenMax     = '1;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_MARK,
    ST_PAD,
    ST_OUT
  } top_state_t;

  // Compression engine states.
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } core_state_t;

  // Requests from the sequencer to the compression engine.
  typedef struct packed {
    logic start;  // compress the block now held in the schedule buffer
    logic init;   // reload the initial hash values
  } core_ctrl_t;

  // Status from the compression engine.
  typedef struct packed {
    logic busy;      // not idle
    logic round_en;  // a round is consuming the schedule word this cycle
    logic done;      // final add cycle, chain words valid next cycle
  } core_stat_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  // Initial hash value for chaining word idx.
  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    init_hash = v;
  endfunction

  // Round constant for round idx.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
    endcase
    round_k = v;
  endfunction

endpackage

// ----- hw/rtl/sha256sh_core.sv -----
// SHA-256 compression engine: one round per cycle through the 64 rounds, then a
// chaining add. Depends on sha256sh_pkg.
module sha256sh_core
  import sha256sh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  core_ctrl_t       ctrl,
  input  logic [31:0]      w_t,
  output core_stat_t       stat,
  output logic [7:0][31:0] chain
);

  core_state_t state, state_next;
  logic [5:0]  round, round_next;
  logic [31:0] work [8];
  logic [31:0] t1, t2, ch, maj;

  // One SHA-256 round on the working variables.
  always_comb begin
    ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
    maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1  = work[7] + big_sigma1(work[4]) + ch + round_k(round) + w_t;
    t2  = big_sigma0(work[0]) + maj;
  end

  // Sequencer next state and status.
  always_comb begin
    state_next    = state;
    round_next    = round;
    stat.busy     = (state != CORE_IDLE);
    stat.round_en = 1'b0;
    stat.done     = 1'b0;
    unique case (state)
      CORE_IDLE: begin
        if (ctrl.start) begin
          state_next = CORE_ROUND;
          round_next = '0;
        end
      end
      CORE_ROUND: begin
        stat.round_en = 1'b1;
        round_next    = round + 6'd1;
        if (round == 6'h3f) begin
          state_next = CORE_ADD;
        end
      end
      CORE_ADD: begin
        stat.done  = 1'b1;
        state_next = CORE_IDLE;
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
    round <= round_next;
  end

  // Working variables: load from the chain, then rotate through the rounds.
  always_ff @(posedge clk) begin
    if (state == CORE_IDLE && ctrl.start) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= chain[i];
      end
    end else if (state == CORE_ROUND) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  // Chaining words: initial values on reset or request, add after a block.
  always_ff @(posedge clk) begin
    if (rst || (state == CORE_IDLE && ctrl.init)) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= init_hash(3'(i));
      end
    end else if (state == CORE_ADD) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + work[i];
      end
    end
  end

endmodule

// ----- hw/rtl/sha256_stream_hasher_top.sv -----
// SHA-256 stream hasher: message bytes arrive at most one per input beat, the
// digest leaves as eight 32-bit beats. The byte that completes a 64-byte
// block holds the input off while the single round unit does the 64 rounds,
// one per cycle, and a chaining add. An end-of-message beat then writes the
// padding one byte per cycle while no compression runs (up to 72 pad bytes
// in one or two blocks, each compressed after its last pad byte) and then
// offers the eight digest beats, word 0 first, with tlast on the eighth.
// Input is not taken until the last digest beat has been accepted. The hash
// state returns to its initial values after each digest. A message longer
// than 2^61-1 bytes drops its excess bytes and flags an over-length error
// on its digest beats.
// Depends on sha256sh_pkg, sha256sh_core and the assertion macro header.
`include "sha256_stream_hasher_top_defines.svh"

module sha256_stream_hasher_top
  import sha256sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_tuser,   // [0] len_overflow
  output logic        m_tlast    // last_word
);

  top_state_t       state, state_next;
  logic [511:0]     blk_data, blk_data_next;
  logic [5:0]       fill, fill_next;
  logic [60:0]      msg_len, msg_len_next;
  logic             too_long, too_long_next;
  logic             eom_pend, eom_pend_next;
  logic             pad_mode, pad_mode_next;
  logic             extra, extra_next;
  logic             final_blk, final_blk_next;
  logic [2:0]       out_idx, out_idx_next;
  core_ctrl_t       core_ctrl;
  core_stat_t       core_stat;
  logic [7:0][31:0] chain;
  logic [31:0]      w_new;
  logic [63:0]      len_bits;
  logic [7:0]       pad_byte;
  logic             out_acc;

  sha256sh_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (core_ctrl),
    .w_t   (blk_data[511:480]),
    .stat  (core_stat),
    .chain (chain)
  );

  // Message schedule expansion on the fixed taps of the block shift line.
  assign w_new = blk_data[511:480] + small_sigma0(blk_data[479:448]) +
                 blk_data[223:192] + small_sigma1(blk_data[63:32]);

  // Padding byte: zeros, then the big-endian bit length in the last eight.
  assign len_bits = {msg_len, 3'b000};
  always_comb begin
    if (extra || fill < 6'(LenPadPos)) begin
      pad_byte = '0;
    end else begin
      pad_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
    end
  end

  assign out_acc = m_tvalid && m_tready;

  // Output beat straight from the chaining words.
  assign m_tdata = {5'b00000, out_idx, chain[out_idx]};
  assign m_tuser = too_long;
  assign m_tlast = (out_idx == 3'd7);

  // Sequencer: byte intake, padding, compression hand-off and digest output.
  always_comb begin
    state_next     = state;
    blk_data_next  = blk_data;
    fill_next      = fill;
    msg_len_next   = msg_len;
    too_long_next  = too_long;
    eom_pend_next  = eom_pend;
    pad_mode_next  = pad_mode;
    extra_next     = extra;
    final_blk_next = final_blk;
    out_idx_next   = out_idx;
    core_ctrl      = '0;
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;

    // The schedule shifts one word per round while the core runs.
    if (core_stat.round_en) begin
      blk_data_next = {blk_data[479:0], w_new};
    end

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          eom_pend_next = s_tlast;
          state_next    = s_tlast ? ST_MARK : ST_IDLE;
          if (s_tuser) begin
            if (msg_len == LenMax) begin
              too_long_next = 1'b1;
            end else begin
              blk_data_next = {blk_data[503:0], s_tdata};
              msg_len_next  = msg_len + 61'd1;
              fill_next     = fill + 6'd1;
              if (fill == 6'(BlockBytes - 1)) begin
                core_ctrl.start = 1'b1;
                final_blk_next  = 1'b0;
                state_next      = ST_COMP;
              end
            end
          end
        end
      end
      ST_MARK: begin
        blk_data_next = {blk_data[503:0], PadMarker};
        fill_next     = fill + 6'd1;
        pad_mode_next = 1'b1;
        eom_pend_next = 1'b0;
        extra_next    = (fill >= 6'(LenPadPos));
        state_next    = ST_PAD;
        if (fill == 6'(BlockBytes - 1)) begin
          // Marker filled the block; the length goes in a fresh one.
          core_ctrl.start = 1'b1;
          final_blk_next  = 1'b0;
          extra_next      = 1'b0;
          state_next      = ST_COMP;
        end
      end
      ST_PAD: begin
        blk_data_next = {blk_data[503:0], pad_byte};
        fill_next     = fill + 6'd1;
        if (fill == 6'(BlockBytes - 1)) begin
          core_ctrl.start = 1'b1;
          final_blk_next  = !extra;
          extra_next      = 1'b0;
          state_next      = ST_COMP;
        end
      end
      ST_COMP: begin
        if (core_stat.done) begin
          if (final_blk) begin
            out_idx_next = '0;
            state_next   = ST_OUT;
          end else if (pad_mode) begin
            state_next = ST_PAD;
          end else if (eom_pend) begin
            state_next = ST_MARK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          out_idx_next = out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            // Digest delivered: start the next message from scratch.
            core_ctrl.init = 1'b1;
            fill_next      = '0;
            msg_len_next   = '0;
            too_long_next  = 1'b0;
            pad_mode_next  = 1'b0;
            final_blk_next = 1'b0;
            extra_next     = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      msg_len   <= '0;
      too_long  <= 1'b0;
      eom_pend  <= 1'b0;
      pad_mode  <= 1'b0;
      extra     <= 1'b0;
      final_blk <= 1'b0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      msg_len   <= msg_len_next;
      too_long  <= too_long_next;
      eom_pend  <= eom_pend_next;
      pad_mode  <= pad_mode_next;
      extra     <= extra_next;
      final_blk <= final_blk_next;
      out_idx   <= out_idx_next;
    end
  end

  // Block buffer and message schedule share one shift line.
  always_ff @(posedge clk) begin
    blk_data <= blk_data_next;
  end

  // Checks on the sequencer and its hand-off to the core.
  `SHS_ASSERT_NOW(a_no_in_during_out, s_tready, !m_tvalid, "input ready while digest pending")
  `SHS_ASSERT_NOW(a_start_when_idle, core_ctrl.start, !core_stat.busy, "core started while busy")
  `SHS_ASSERT_NEXT(a_start_full_block, core_ctrl.start, fill == 6'd0, "compression of a partial block")
  `SHS_ASSERT_NEXT(a_clean_after_digest, out_acc && m_tlast, s_tready && fill == 6'd0 && msg_len == 61'd0 && !too_long, "state not cleared after digest")

endmodule

// ----- bench/sha256_digest_checker.sv -----
// Checker for the SHA-256 stream hasher: watches both stream channels, predicts
// the eight digest beats of every message and compares them as they leave.
// Depends on sha256sh_pkg for the block geometry and padding constants.
module sha256_digest_checker
  import sha256sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  input  logic        m_tuser,   // [0] len_overflow
  input  logic        m_tlast,   // last_word
  input  logic        end_of_run,
  output int          fail_count,
  output int          pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPrinted = 40;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        len_err;
  } digest_beat_t;

  // Predicted hash state of the message in flight.
  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int           fill;
  logic [60:0]  msg_len;
  logic         overlong;
  digest_beat_t digest_q [$];
  logic         leftover_flagged;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    logic [63:0] d;
    d = {v, v} >> n;
    return d[31:0];
  endfunction

  // One SHA-256 compression of the block buffer into the chaining words.
  function automatic void compress_buffer();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, x, y;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7]
           + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 8; i++) chain[i] = START_HASH[i];
    fill = 0;
    msg_len = '0;
    overlong = 1'b0;
  endfunction

  // A byte past the length limit is dropped and only marks the message.
  function automatic void take_byte(input logic [7:0] b);
    if (msg_len == LenMax) begin
      overlong = 1'b1;
    end else begin
      msg_len = msg_len + 61'd1;
      blk[fill] = b;
      fill++;
      if (fill == int'(BlockBytes)) begin
        compress_buffer();
        fill = 0;
      end
    end
  endfunction

  // Pad, run the final compressions and queue the eight digest beats.
  function automatic void close_message();
    logic [63:0]  bit_len;
    digest_beat_t e;
    int pos;
    int i;
    bit_len = {msg_len, 3'b000};
    pos = fill;
    blk[pos] = PadMarker;
    pos++;
    if (pos > int'(LenPadPos)) begin
      while (pos < int'(BlockBytes)) begin
        blk[pos] = 8'h00;
        pos++;
      end
      compress_buffer();
      pos = 0;
    end
    while (pos < int'(LenPadPos)) begin
      blk[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
    compress_buffer();
    for (i = 0; i < 8; i++) begin
      e.word = chain[i];
      e.idx = 3'(i);
      e.last = (i == 7);
      e.len_err = overlong;
      digest_q.push_back(e);
    end
    restart_hash();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MaxPrinted) begin
      $display("[%0t] digest beat %0d: %s, got %h, expected %h",
               $time, words_checked, what, got, want);
    end
    fail_count++;
  endtask

  // Output beats are compared before input beats are taken in, so a digest
  // queued on this edge never meets a beat of the previous message.
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      restart_hash();
      digest_q.delete();
      fail_count = 0;
      words_checked = 0;
      leftover_flagged = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("beat with no digest pending", m_tdata[31:0], 32'd0);
        end else begin
          want = digest_q.pop_front();
          if (m_tdata[31:0] !== want.word)
            report_mismatch("digest_word", m_tdata[31:0], want.word);
          if (m_tdata[34:32] !== want.idx)
            report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(want.idx));
          if (m_tdata[39:35] !== 5'd0)
            report_mismatch("tdata fill bits", 32'(m_tdata[39:35]), 32'd0);
          if (m_tlast !== want.last)
            report_mismatch("last_word", 32'(m_tlast), 32'(want.last));
          if (m_tuser !== want.len_err)
            report_mismatch("len_overflow", 32'(m_tuser), 32'(want.len_err));
        end
        words_checked++;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) take_byte(s_tdata);
        if (s_tlast) close_message();
      end
      if (end_of_run && !leftover_flagged) begin
        leftover_flagged = 1'b1;
        if (digest_q.size() != 0)
          report_mismatch("digest beats never delivered", 32'(digest_q.size()), 32'd0);
      end
    end
    pending = digest_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the SHA-256 stream hasher bench: clock, reset, byte stimulus with
// random gaps and back-pressure, and the verdict.
// Depends on sha256_stream_hasher_top, sha256_digest_checker and sha256sh_pkg.
module tb_top;
  import sha256sh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 270;
  localparam int CycleLimit = 400000;
  // Worst end of message: 72 pad bytes, two compressions, eight beats.
  localparam int DrainCycles = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        end_of_run;

  int fail_count;
  int pending;
  int words_checked;
  int cycle_count = 0;
  int items_sent = 0;
  int n_messages = 0;
  int n_bytes = 0;
  int n_ignored = 0;
  int out_beats = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  always #2 clk = ~clk;

  sha256_stream_hasher_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sha256_digest_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .end_of_run    (end_of_run),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d digest beats pending", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One input beat: optional gap, then hold until accepted. Entered and left
  // at a falling edge.
  task automatic send_beat(input logic [7:0] d, input logic has_byte, input logic eom);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= has_byte;
    s_tlast  <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (!(has_byte || eom)) n_ignored++;
    if (has_byte) n_bytes++;
    if (eom) n_messages++;
  endtask

  // A message of random bytes, with stray empty beats mixed in and the end
  // flag either on the last byte or on a beat of its own.
  task automatic send_message(input int len);
    bit split_end;
    int k;
    split_end = (len == 0) || ($urandom_range(0, 1) == 0);
    tx_quiet = ($urandom_range(0, 3) == 0);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1, !split_end && (k == len - 1));
    end
    if (split_end) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Receiver: a random stall before every digest beat, with quiet stretches.
  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = rx_quiet ? 0 : $urandom_range(0, 7);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
      out_beats++;
      if (out_beats % 8 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // Stimulus and verdict.
  initial begin
    int len;
    int pick;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tuser    = 1'b0;
    s_tlast    = 1'b0;
    end_of_run = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: an empty beat that must be ignored, the empty message,
    // field extremes, end with and without a byte, and a stray beat mid-message.
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h55, 1'b1, 1'b0);
    send_beat(8'h3C, 1'b0, 1'b0);
    send_beat(8'hAA, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);

    // Random messages, many of them near the padding and block boundaries.
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(0, 12);
      end else if (pick < 85) begin
        case ($urandom_range(0, 6))
          0:       len = int'(LenPadPos) - 2;
          1:       len = int'(LenPadPos) - 1;
          2:       len = int'(LenPadPos);
          3:       len = int'(LenPadPos) + 1;
          4:       len = int'(BlockBytes) - 1;
          5:       len = int'(BlockBytes);
          default: len = int'(BlockBytes) + 1;
        endcase
      end else begin
        len = $urandom_range(13, 40);
      end
      // The last message is cut short so the run stays near its beat budget.
      if (len > ItemTarget - items_sent) len = ItemTarget - items_sent;
      send_message(len);
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    end_of_run <= 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("Sent %0d messages, %0d message bytes and %0d ignored beats;",
             n_messages, n_bytes, n_ignored);
    $display("checked %0d digest beats under random gaps and back-pressure.", words_checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
